### hw/rtl/ret_pkg.sv
// ret_pkg: shared types, constants and reset values for the rain episode tracker
// used by every module under hw/rtl; depends on nothing
package ret_pkg;

	// field widths
	localparam int SAMPLE_BITS   = 10;
	localparam int THR_BITS      = 10;
	localparam int DUR_BITS      = 16;
	localparam int TIME_BITS     = 32;
	localparam int LEVEL_BITS    = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int CMP_BITS      = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

	// request queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef logic [LEVEL_BITS-1:0] level_t;

	// rain levels
	localparam level_t LVL_NONE     = 2'd0;
	localparam level_t LVL_MIST     = 2'd1;
	localparam level_t LVL_MODERATE = 2'd2;
	localparam level_t LVL_INTENSE  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_NONE_THR     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIST_THR     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODERATE_THR = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DURATION = 2'd3;

	// configuration reset values
	localparam logic [THR_BITS-1:0] NONE_THR_RST     = 10'd700;
	localparam logic [THR_BITS-1:0] MIST_THR_RST     = 10'd600;
	localparam logic [THR_BITS-1:0] MODERATE_THR_RST = 10'd400;
	localparam logic [DUR_BITS-1:0] MIN_DURATION_RST = 16'd60;

	// input request
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [TIME_BITS-1:0]   now_seconds;
	} ret_in_t;

	// result
	typedef struct packed {
		level_t                 intensity;
		logic [TIME_BITS-1:0]   seconds_raining;
		logic [TIME_BITS-1:0]   report_start;
		logic [TIME_BITS-1:0]   report_duration;
		level_t                 report_level;
	} ret_out_t;

	// classified request held in the queue
	typedef struct packed {
		level_t               level;
		logic [TIME_BITS-1:0] now_seconds;
	} ret_qitem_t;

	// classification thresholds
	typedef struct packed {
		logic [THR_BITS-1:0] none_thr;
		logic [THR_BITS-1:0] mist_thr;
		logic [THR_BITS-1:0] moderate_thr;
	} ret_thr_t;

endpackage

### hw/rtl/ret_front.sv
// ret_front: accepts sample requests, classifies them into a rain level
// and hands them to the queue; depends on ret_pkg
module ret_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  ret_pkg::ret_in_t  sample_data,
	input  ret_pkg::ret_thr_t thr,
	output logic              push_valid,
	input  logic              push_ready,
	output ret_pkg::ret_qitem_t push_item
);
	import ret_pkg::*;

	logic             valid_s1;
	ret_qitem_t       item_s1;
	level_t           level;
	logic [CMP_BITS-1:0] smp;
	logic             accept;

	// threshold compare, first match wins
	always_comb begin
		smp = CMP_BITS'(sample_data.sample);
		if (smp >= CMP_BITS'(thr.none_thr)) begin
			level = LVL_NONE;
		end else if (smp >= CMP_BITS'(thr.mist_thr)) begin
			level = LVL_MIST;
		end else if (smp >= CMP_BITS'(thr.moderate_thr)) begin
			level = LVL_MODERATE;
		end else begin
			level = LVL_INTENSE;
		end
	end

	assign sample_stall = valid_s1 && !push_ready;
	assign accept       = sample_valid && !sample_stall;

	// stage register in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.level       <= level;
			item_s1.now_seconds <= sample_data.now_seconds;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

### hw/rtl/ret_queue.sv
// ret_queue: short request queue between the classifier and the tracker
// depends on ret_pkg
module ret_queue #(
	parameter int DEPTH = ret_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  ret_pkg::ret_qitem_t push_item,
	output logic                pop_valid,
	input  logic                pop,
	output ret_pkg::ret_qitem_t pop_item
);
	import ret_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ret_qitem_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### hw/rtl/ret_back.sv
// ret_back: episode state update, record keeping and result register
// depends on ret_pkg
module ret_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_pop,
	input  ret_pkg::ret_qitem_t        item,
	input  logic [ret_pkg::DUR_BITS-1:0] min_duration,
	output logic                       result_valid,
	input  logic                       result_stall,
	output ret_pkg::ret_out_t          result_data
);
	import ret_pkg::*;

	level_t               cur_q, peak_q, rec_level_q;
	logic [TIME_BITS-1:0] start_q, rec_start_q, rec_dur_q;
	logic                 result_valid_q;
	ret_out_t             result_q;

	level_t               cur_n, peak_n, rec_level_n;
	logic [TIME_BITS-1:0] start_n, rec_start_n, rec_dur_n;
	logic [TIME_BITS-1:0] dur, elapsed, min_dur_ext;
	logic                 live;
	ret_out_t             res_n;

	assign item_pop    = item_valid && (!result_valid_q || !result_stall);
	assign min_dur_ext = TIME_BITS'(min_duration);
	assign dur         = item.now_seconds - start_q;

	// state update on a level change
	always_comb begin
		cur_n       = cur_q;
		peak_n      = peak_q;
		start_n     = start_q;
		rec_start_n = rec_start_q;
		rec_dur_n   = rec_dur_q;
		rec_level_n = rec_level_q;
		if (item.level != cur_q) begin
			if (item.level != LVL_NONE && start_q == '0) begin
				start_n = item.now_seconds;
			end
			if (item.level > peak_q) begin
				peak_n = item.level;
			end
			if (item.level == LVL_NONE && cur_q != LVL_NONE) begin
				if (start_q != '0 && dur >= min_dur_ext) begin
					rec_start_n = start_q;
					rec_dur_n   = dur;
					rec_level_n = peak_n;
					peak_n      = LVL_NONE;
				end
				start_n = '0;
			end
			cur_n = item.level;
		end
	end

	// result from the updated state
	always_comb begin
		elapsed               = item.now_seconds - start_n;
		live                  = (cur_n >= LVL_MODERATE) && (start_n != '0) &&
		                        (elapsed >= min_dur_ext);
		res_n.intensity       = cur_n;
		res_n.seconds_raining = (start_n != '0) ? elapsed : '0;
		if (live) begin
			res_n.report_start    = start_n;
			res_n.report_duration = elapsed;
			res_n.report_level    = cur_n;
		end else begin
			res_n.report_start    = rec_start_n;
			res_n.report_duration = rec_dur_n;
			res_n.report_level    = rec_level_n;
		end
	end

	// episode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= LVL_NONE;
			peak_q      <= LVL_NONE;
			start_q     <= '0;
			rec_start_q <= '0;
			rec_dur_q   <= '0;
			rec_level_q <= LVL_NONE;
		end else if (item_pop) begin
			cur_q       <= cur_n;
			peak_q      <= peak_n;
			start_q     <= start_n;
			rec_start_q <= rec_start_n;
			rec_dur_q   <= rec_dur_n;
			rec_level_q <= rec_level_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_pop) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			result_q <= res_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

### hw/rtl/rain_episode_tracker.sv
// rain_episode_tracker: top level, configuration registers and the
// classifier / queue / tracker chain; depends on ret_pkg, ret_front, ret_queue, ret_back
//
// usage
//  - sample channel: sample_valid / sample_stall / sample_data (sample, now_seconds);
//    a request is taken at a clock edge with sample_valid high and sample_stall low
//  - result channel: result_valid / result_stall / result_data; one result per
//    request, in order; result_data holds while result_stall is high
//  - configuration: cfg_we, cfg_index, cfg_data; write only while the block is idle
//    (0 none threshold, 1 mist threshold, 2 moderate threshold, 3 min duration)
//  - path: a request passes the classifier stage register, the queue and the output
//    register before its result shows; throughput: one request per cycle while
//    result_stall is low, set by the state update in the tracker stage
//  - receiver stall: the output register, the queue (QUEUE_DEPTH entries) and the
//    classifier stage keep filling; sample_stall rises once the queue and the
//    classifier stage are both full
//  - reset: thresholds and min duration go to 700/600/400/60, the episode state
//    and the stored record clear, all buffers empty
module rain_episode_tracker #(
	parameter int QUEUE_DEPTH = ret_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  ret_pkg::ret_in_t                  sample_data,
	output logic                              result_valid,
	input  logic                              result_stall,
	output ret_pkg::ret_out_t                 result_data,
	input  logic                              cfg_we,
	input  logic [ret_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ret_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import ret_pkg::*;

	ret_thr_t            thr_q;
	logic [DUR_BITS-1:0] min_dur_q;

	logic       push_valid, push_ready;
	ret_qitem_t push_item;
	logic       pop_valid, pop;
	ret_qitem_t pop_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.none_thr     <= NONE_THR_RST;
			thr_q.mist_thr     <= MIST_THR_RST;
			thr_q.moderate_thr <= MODERATE_THR_RST;
			min_dur_q          <= MIN_DURATION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NONE_THR:     thr_q.none_thr     <= cfg_data[THR_BITS-1:0];
				CFG_MIST_THR:     thr_q.mist_thr     <= cfg_data[THR_BITS-1:0];
				CFG_MODERATE_THR: thr_q.moderate_thr <= cfg_data[THR_BITS-1:0];
				CFG_MIN_DURATION: min_dur_q          <= cfg_data[DUR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// classifier
	ret_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.thr          (thr_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	// request queue
	ret_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	// episode tracker
	ret_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (pop_valid),
		.item_pop     (pop),
		.item         (pop_item),
		.min_duration (min_dur_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

### hw/rtl/ret_checker.sv
// ret_checker: port-level checks for the rain episode tracker, bound to the top level
// depends on ret_pkg and rain_episode_tracker
module ret_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_stall,
	input logic              result_valid,
	input logic              result_stall,
	input ret_pkg::ret_out_t result_data
);
	import ret_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result changed");

	// no rain means no running timer
	a_dry_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.intensity == LVL_NONE |->
		result_data.seconds_raining == '0)
		else $error("timer running while dry");

	// the input only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("sample stalled with no result waiting");

	// an empty stored record carries no level
	a_report_level: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.report_duration == '0 &&
		result_data.report_start == '0 |-> result_data.report_level == LVL_NONE)
		else $error("empty record with a level");

endmodule

bind rain_episode_tracker ret_checker u_ret_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);
